// ===== rtl/slcd_pkg.sv =====
`default_nettype none

package slcd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned SUM_W = 16;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] data_byte;
    kind_t             result_kind;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/slcd_parser.sv =====
`default_nettype none

module slcd_parser (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [slcd_pkg::BYTE_W-1:0]   cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [slcd_pkg::BYTE_W-1:0]   in_tdata,
  input  wire logic                          out_space,
  output logic                               res_valid,
  output slcd_pkg::result_t                  res
);

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_TYPE    = 7'b0000010,
    PH_LEN_HI  = 7'b0000100,
    PH_LEN_LO  = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_CK_HI   = 7'b0100000,
    PH_CK_LO   = 7'b1000000
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [slcd_pkg::BYTE_W-1:0]     sync_r, sync_nxt;
  logic [slcd_pkg::BYTE_W-1:0]     type_r, type_nxt;
  logic [slcd_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [slcd_pkg::LEN_W-1:0]      left_r, left_nxt;
  logic [slcd_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [slcd_pkg::BYTE_W-1:0]     ckhi_r, ckhi_nxt;
  logic                            in_valid_r, in_valid_nxt;
  logic [slcd_pkg::BYTE_W-1:0]     in_byte_r, in_byte_nxt;

  logic                            adv;
  logic [slcd_pkg::SUM_W-1:0]      sum_add;
  logic [slcd_pkg::LEN_W-1:0]      len_full;
  logic [slcd_pkg::LEN_W-1:0]      left_dec;
  logic [slcd_pkg::SUM_W-1:0]      rx_sum;

  assign adv       = in_valid_r && out_space;
  assign in_tready = !in_valid_r || out_space;

  assign sum_add  = sum_r + {{(slcd_pkg::SUM_W-slcd_pkg::BYTE_W){1'b0}}, in_byte_r};
  assign len_full = {len_r[slcd_pkg::LEN_W-1:slcd_pkg::BYTE_W], in_byte_r};
  assign left_dec = left_r - {{(slcd_pkg::LEN_W-1){1'b0}}, 1'b1};
  assign rx_sum   = {ckhi_r, in_byte_r};

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_byte_nxt  = in_byte_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
      in_byte_nxt  = in_tdata;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
  end

  assign sync_nxt = cfg_we ? cfg_wdata : sync_r;

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    sum_nxt   = sum_r;
    ckhi_nxt  = ckhi_r;
    res_valid = 1'b0;
    res.result_kind  = slcd_pkg::KIND_DATA;
    res.data_byte    = '0;
    res.frame_type   = type_r;
    res.frame_length = len_r;
    if (adv) begin
      case (phase_r)
        PH_TYPE: begin
          type_nxt  = in_byte_r;
          sum_nxt   = sum_add;
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt   = {in_byte_r, {slcd_pkg::BYTE_W{1'b0}}};
          sum_nxt   = sum_add;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = len_full;
          left_nxt  = len_full;
          sum_nxt   = sum_add;
          phase_nxt = (len_full == '0) ? PH_CK_HI : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_nxt   = sum_add;
          left_nxt  = left_dec;
          if (left_dec == '0) begin
            phase_nxt = PH_CK_HI;
          end
          res_valid     = 1'b1;
          res.data_byte = in_byte_r;
        end
        PH_CK_HI: begin
          ckhi_nxt  = in_byte_r;
          phase_nxt = PH_CK_LO;
        end
        PH_CK_LO: begin
          phase_nxt       = PH_HUNT;
          res_valid       = 1'b1;
          res.result_kind = (rx_sum == sum_r) ? slcd_pkg::KIND_GOOD : slcd_pkg::KIND_BAD;
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (in_byte_r == sync_r) begin
            sum_nxt   = {{(slcd_pkg::SUM_W-slcd_pkg::BYTE_W){1'b0}}, in_byte_r};
            phase_nxt = PH_TYPE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      sync_r     <= slcd_pkg::SYNC_RESET;
      type_r     <= '0;
      len_r      <= '0;
      left_r     <= '0;
      sum_r      <= '0;
      ckhi_r     <= '0;
      in_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      sync_r     <= sync_nxt;
      type_r     <= type_nxt;
      len_r      <= len_nxt;
      left_r     <= left_nxt;
      sum_r      <= sum_nxt;
      ckhi_r     <= ckhi_nxt;
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
  end

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r != '0)
    else $error("payload phase with no bytes left");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    adv && phase_r == PH_LEN_LO && len_full == '0 |=> phase_r == PH_CK_HI)
    else $error("zero length frame did not go to checksum");

  a_end_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    adv && phase_r == PH_CK_LO |=> phase_r == PH_HUNT)
    else $error("no return to hunt after checksum");

  a_res_space: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> out_space && in_valid_r)
    else $error("result produced without room in output register");

endmodule

`default_nettype wire

// ===== rtl/slcd_out_stage.sv =====
`default_nettype none

module slcd_out_stage (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              res_valid,
  input  wire slcd_pkg::result_t                 res,
  output logic                                   out_space,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [slcd_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic [1:0]                             out_tuser
);

  logic               valid_r, valid_nxt;
  slcd_pkg::result_t  res_r, res_nxt;

  assign out_space = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.frame_length, res_r.frame_type, res_r.data_byte};
  assign out_tuser  = res_r.result_kind;

endmodule

`default_nettype wire

// ===== rtl/sync_length_checksum_deframer_top.sv =====
// Byte stream deframer: hunts for the sync byte (cfg register, reset 0xAA), then reads a type
// byte, a big-endian 16-bit length, the payload and a big-endian 16-bit checksum that is the
// wrapping 16-bit sum of sync, type, length and payload bytes. Each payload byte comes out at
// once as a tentative word (tuser 0); after the checksum one word reports good (1) or bad (2),
// and the consumer drops the tentative bytes of a bad frame. Every output word carries the
// frame's type and declared length. One byte is taken every clock cycle while the output
// accepts; an accepted byte passes through the input register and the result register to the
// output, and the bytes of the header, the checksum high byte and hunted bytes give no word.
// Back-pressure on the output stalls the input after one buffered byte. No clearing pass.
`default_nettype none

module sync_length_checksum_deframer_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [slcd_pkg::BYTE_W-1:0]       cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [slcd_pkg::BYTE_W-1:0]       in_tdata,   // in_byte
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [slcd_pkg::OUT_DATA_W-1:0]        out_tdata,  // data_byte, frame_type, frame_length
  output logic [1:0]                             out_tuser   // result_kind
);

  logic               res_valid;
  logic               out_space;
  slcd_pkg::result_t  res;

  slcd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_space (out_space),
    .res_valid (res_valid),
    .res       (res)
  );

  slcd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .out_space  (out_space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
